@@ rtl/fts_pkg.sv @@
// Shared types, codes and helpers for the FIFO task scheduler.
package fts_pkg;

    localparam int NUM_TASKS = 16;
    localparam int TASK_W    = 4;
    localparam int COUNT_W   = 5;

    typedef logic [TASK_W-1:0]  task_id_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [2:0]         task_state_t;

    // request operations
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_REPORT   = 2'd2;

    // report outcomes
    localparam logic [1:0] OUT_YIELD     = 2'd0;
    localparam logic [1:0] OUT_EXIT      = 2'd1;
    localparam logic [1:0] OUT_EXCEPTION = 2'd2;

    // per-task states
    localparam task_state_t TS_FREE     = 3'd0;
    localparam task_state_t TS_READY    = 3'd1;
    localparam task_state_t TS_RUNNING  = 3'd2;
    localparam task_state_t TS_BLOCKED  = 3'd3;
    localparam task_state_t TS_FINISHED = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD          = 3'd1;
    localparam logic [2:0] ST_ALL_DONE     = 3'd2;
    localparam logic [2:0] ST_DEADLOCK     = 3'd3;
    localparam logic [2:0] ST_UNHANDLED    = 3'd4;
    localparam logic [2:0] ST_PARENT_BAD   = 3'd5;
    localparam logic [2:0] ST_NONE_RUNNING = 3'd6;
    localparam logic [2:0] ST_BUSY         = 3'd7;

    typedef struct packed {
        logic [1:0] operation;
        task_id_t   task_id;
        logic [1:0] outcome;
        logic       has_parent;
        task_id_t   parent_id;
    } fts_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       task_valid;
        task_id_t   dispatched_task;
        count_t     ready_count;
        count_t     blocked_count;
    } fts_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming item
        logic commit;  // apply the held item and load the result register
    } fts_cmd_t;

    // FIFO pointer advance, wrapping at NUM_TASKS
    function automatic task_id_t next_ptr(input task_id_t p);
        task_id_t r;
        if (32'(p) == NUM_TASKS - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

@@ rtl/fts_ctrl.sv @@
// Sequencing controller for the FIFO task scheduler: capture, execute, result handshake.
module fts_ctrl
    import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output fts_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic slot_free;

    // result slot can take a new result this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/fts_datapath.sv @@
// Datapath of the FIFO task scheduler: task state table, ready FIFO, counters, result register.
module fts_datapath
    import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fts_cmd_t cmd,
    input  fts_req_t req,
    output fts_rsp_t rsp
);

    fts_req_t    item_reg;
    fts_rsp_t    rsp_reg;
    fts_rsp_t    rsp_next;

    task_state_t st_reg  [NUM_TASKS];
    task_state_t st_next [NUM_TASKS];
    task_id_t    fifo_reg [NUM_TASKS];

    task_id_t    head_reg, head_next;
    task_id_t    tail_reg, tail_next;
    count_t      ready_reg, ready_next;
    count_t      blocked_reg, blocked_next;
    logic        run_valid_reg, run_valid_next;
    task_id_t    run_task_reg, run_task_next;

    logic        fifo_we;
    logic        wake_req;
    logic        wake_parent;
    logic        wake_ok;
    task_id_t    wake_id;
    task_state_t wake_state;
    task_id_t    head_task;

    assign head_task = fifo_reg[head_reg];

    always_comb
    begin
        st_next        = st_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ready_next     = ready_reg;
        blocked_next   = blocked_reg;
        run_valid_next = run_valid_reg;
        run_task_next  = run_task_reg;
        fifo_we        = 1'b0;
        wake_req       = 1'b0;
        wake_parent    = 1'b0;
        wake_ok        = 1'b1;
        wake_id        = item_reg.task_id;
        wake_state     = TS_FREE;
        rsp_next.status          = ST_OK;
        rsp_next.task_valid      = 1'b0;
        rsp_next.dispatched_task = '0;

        unique case (item_reg.operation)
            OP_SCHEDULE:
            begin
                wake_req = 1'b1;
            end
            OP_DISPATCH:
            begin
                if (run_valid_reg)
                begin
                    rsp_next.status = ST_BUSY;
                end
                else if (ready_reg == '0)
                begin
                    rsp_next.status = (blocked_reg != '0) ? ST_DEADLOCK : ST_ALL_DONE;
                end
                else
                begin
                    head_next                = next_ptr(head_reg);
                    ready_next               = ready_reg - 1'b1;
                    st_next[head_task]       = TS_RUNNING;
                    run_valid_next           = 1'b1;
                    run_task_next            = head_task;
                    rsp_next.task_valid      = 1'b1;
                    rsp_next.dispatched_task = head_task;
                end
            end
            OP_REPORT:
            begin
                if (!run_valid_reg)
                begin
                    rsp_next.status = ST_NONE_RUNNING;
                end
                else
                begin
                    run_valid_next = 1'b0;
                    if (item_reg.outcome == OUT_EXIT || item_reg.outcome == OUT_EXCEPTION)
                    begin
                        st_next[run_task_reg] = TS_FINISHED;
                        if (item_reg.has_parent)
                        begin
                            wake_req    = 1'b1;
                            wake_parent = 1'b1;
                            wake_id     = item_reg.parent_id;
                        end
                        else if (item_reg.outcome == OUT_EXCEPTION)
                        begin
                            rsp_next.status = ST_UNHANDLED;
                        end
                    end
                    else
                    begin
                        // yield, and the unused outcome code, block the task
                        st_next[run_task_reg] = TS_BLOCKED;
                        blocked_next          = blocked_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                // unused operation: no change
            end
        endcase

        // wake: reads the updated table so a parent that just finished is seen as such
        if (wake_req)
        begin
            if (32'(wake_id) >= NUM_TASKS)
            begin
                wake_ok = 1'b0;
            end
            else
            begin
                wake_state = st_next[wake_id];
                if (wake_state == TS_READY || wake_state == TS_RUNNING)
                begin
                    wake_ok = 1'b1;
                end
                else if (wake_state == TS_BLOCKED || wake_state == TS_FREE)
                begin
                    if (wake_state == TS_BLOCKED && blocked_next != '0)
                    begin
                        blocked_next = blocked_next - 1'b1;
                    end
                    if (32'(ready_next) >= NUM_TASKS)
                    begin
                        wake_ok = 1'b0;
                    end
                    else
                    begin
                        st_next[wake_id] = TS_READY;
                        fifo_we          = 1'b1;
                        tail_next        = next_ptr(tail_reg);
                        ready_next       = ready_next + 1'b1;
                    end
                end
                else
                begin
                    wake_ok = 1'b0;
                end
            end
            if (!wake_ok)
            begin
                rsp_next.status = wake_parent ? ST_PARENT_BAD : ST_BAD;
            end
        end

        rsp_next.ready_count   = ready_next;
        rsp_next.blocked_count = blocked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                st_reg[i] <= TS_FREE;
            end
            head_reg      <= '0;
            tail_reg      <= '0;
            ready_reg     <= '0;
            blocked_reg   <= '0;
            run_valid_reg <= 1'b0;
            run_task_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            st_reg        <= st_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            ready_reg     <= ready_next;
            blocked_reg   <= blocked_next;
            run_valid_reg <= run_valid_next;
            run_task_reg  <= run_task_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
            if (fifo_we)
            begin
                fifo_reg[tail_reg] <= wake_id;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ rtl/fifo_task_scheduler.sv @@
// Top level of the cooperative FIFO task scheduler.
// Each item is one request: schedule a task, dispatch the next ready task, or
// report the outcome of the running task; each gives exactly one result item.
// An item is first captured, and then it updates the task state table, the
// ready FIFO and the counters and loads the result register. The next
// item is taken while a result still waits for the downstream side; a result
// that is stalled holds the update of the following item, since only one result
// register stands at the output. Tasks start free after reset, with no clearing
// pass. Status codes: 0 ok, 1 bad state, 2 all done, 3 deadlock, 4 unhandled
// exception, 5 parent bad state, 6 none running, 7 busy.
module fifo_task_scheduler
    import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // request channel
    input  logic     req_valid,
    output logic     req_stall,
    input  fts_req_t req,
    // result channel
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output fts_rsp_t rsp
);

    fts_cmd_t cmd;

    // sequencing: capture, execute, result handshake
    fts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // task table, ready FIFO, counters and result register
    fts_datapath u_dp (
        .clk (clk),
        .rst_n (rst_n),
        .cmd (cmd),
        .req (req),
        .rsp (rsp)
    );

`ifndef SYNTHESIS
    // only one item in flight: an accept is followed by a stalled cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while an item is in flight");

    // ready and blocked tasks are disjoint sets of tasks
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((6'(rsp.ready_count) + 6'(rsp.blocked_count)) <= 6'(NUM_TASKS)))
        else $error("ready plus blocked count exceeds task count");

    // a dispatched task always comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.task_valid) |-> (rsp.status == ST_OK))
        else $error("dispatched task with error status");
`endif

endmodule
